/* sv/pcg32_pkg.sv */
// Shared types, constants and the output permutation of the PCG32 generator.
`default_nettype none

package pcg32_pkg;

	// LCG multiplier and increment; the multiplier is split into 32-bit halves for the shared multiplier
	localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
	localparam logic [63:0] LCG_INC = 64'd1442695040888963407;
	localparam logic [31:0] LCG_MUL_LO = LCG_MUL[31:0];
	localparam logic [31:0] LCG_MUL_HI = LCG_MUL[63:32];

	// XSH-RR shift amounts
	localparam int XSH_SHIFT = 18;
	localparam int XSH_BASE  = 27;
	localparam int ROT_LSB   = 59;

	// Remainder unit width and step counter width
	localparam int DIV_W     = 32;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	// Request opcodes
	typedef enum logic [2:0] {
		OP_RAW32 = 3'd0,
		OP_BND32 = 3'd1,
		OP_RAW16 = 3'd2,
		OP_BND16 = 3'd3,
		OP_COIN  = 3'd4
	} op_t;

	// Control towards the LCG state unit
	typedef struct packed {
		logic        load;
		logic        start;
		logic [63:0] seed;
	} lcg_req_t;

	// Control towards the remainder unit
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	// XSH-RR output permutation of a 64-bit state
	function automatic logic [31:0] pcg_out(input logic [63:0] s);
		logic [63:0] x;
		logic [31:0] mixed;
		logic [4:0]  rot;
		logic [63:0] dbl;
		x     = (s >> XSH_SHIFT) ^ s;
		mixed = x[XSH_BASE+31:XSH_BASE];
		rot   = s[ROT_LSB+4:ROT_LSB];
		dbl   = {mixed, mixed} >> rot;
		return dbl[31:0];
	endfunction

endpackage

`default_nettype wire

/* sv/pcg32_lcg.sv */
// 64-bit LCG state register, advanced by accumulating partial products on one 32x32 multiplier.
`default_nettype none

module pcg32_lcg
	import pcg32_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire lcg_req_t    req,
	output logic [63:0]      state,
	output logic             busy
);

	logic [63:0] state_q;
	logic [63:0] acc_q;
	logic [63:0] prod_q;
	logic [1:0]  step_q;
	logic        busy_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [63:0] addend;
	logic [63:0] acc_sum;

	// Partial products: lo*lo, lo*hi, hi*lo (hi*hi falls off the top)
	always_comb begin
		unique case (step_q)
			2'd0: begin
				mul_a = state_q[31:0];
				mul_b = LCG_MUL_LO;
			end
			2'd1: begin
				mul_a = state_q[31:0];
				mul_b = LCG_MUL_HI;
			end
			default: begin
				mul_a = state_q[63:32];
				mul_b = LCG_MUL_LO;
			end
		endcase
	end

	assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

	// First product adds in full, cross products only in the upper word
	assign addend  = (step_q == 2'd1) ? prod_q : {prod_q[31:0], 32'd0};
	assign acc_sum = acc_q + addend;

	// Step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			acc_q   <= '0;
			prod_q  <= '0;
			step_q  <= '0;
			busy_q  <= 1'b0;
		end else if (req.load) begin
			state_q <= req.seed;
			busy_q  <= 1'b0;
		end else if (req.start) begin
			acc_q  <= LCG_INC;
			step_q <= 2'd0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			prod_q <= mul_p;
			step_q <= step_q + 2'd1;
			if (step_q != 2'd0)
				acc_q <= acc_sum;
			if (step_q == 2'd3) begin
				state_q <= acc_sum;
				busy_q  <= 1'b0;
			end
		end
	end

	assign state = state_q;
	assign busy  = busy_q;

endmodule

`default_nettype wire

/* sv/pcg32_rem.sv */
// Restoring remainder unit: one quotient bit per cycle.
`default_nettype none

module pcg32_rem
	import pcg32_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire div_req_t         req,
	output logic                  busy,
	output logic [DIV_W-1:0]      rem
);

	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     dvd_q;
	logic [DIV_W-1:0]     dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;

	logic [DIV_W:0] trial;
	logic [DIV_W:0] diff;
	logic           fits;

	// Shift in the next dividend bit and try the subtract
	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dvd_q  <= '0;
			dsr_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (req.start) begin
			rem_q  <= '0;
			dvd_q  <= req.dividend;
			dsr_q  <= req.divisor;
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_W - 1))
				busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

/* sv/pcg32_random_generator_unit.sv */
// PCG32 (XSH-RR) random generator with bounded, half-word and coin-flip requests.
//
// One request is taken at a time. Raw 32-bit requests, fresh raw 16-bit requests
// and fresh coins advance the LCG state; the 64-bit LCG advance runs as four steps
// on one 32x32 multiplier. A cached 16-bit half or cached coin bit needs no advance.
// Bounded requests run the 32-step remainder unit twice (threshold, then final
// modulo) around the draws. A rejected draw is followed by another draw, from a
// fresh word or, for bounded16, from the cached half. A zero bound or an unused
// opcode answers with value 0; bad_bound is set only for the zero bound. The result
// register lets a new request enter while the previous result waits on m_tready.
// Writing the seed reloads the state and drops the cached half and coin bits.
// Write it only while no request is in flight.
`default_nettype none

module pcg32_random_generator_unit
	import pcg32_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// seed register
	input  wire logic        seed_wr_en,
	input  wire logic [63:0] seed_wr_data,
	// request: [2:0] opcode, [34:3] bound, [39:35] zero
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,
	// result: [31:0] value
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,
	// result: [0] bad_bound
	output logic             m_tuser
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_THR  = 7'b0000010,
		S_DRAW = 7'b0000100,
		S_ADV  = 7'b0001000,
		S_MODD = 7'b0010000,
		S_COIN = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t      state_q;
	op_t         op_q;
	logic [31:0] bnd_q;
	logic [31:0] thr_q;
	logic [31:0] r_q;
	logic [31:0] res_q;
	logic        bad_q;
	logic        pending_q;
	logic [15:0] upper_q;
	logic [31:0] coin_word_q;
	logic [5:0]  coins_left_q;
	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;
	logic        m_tuser_q;

	logic        accept;
	op_t         op_in;
	logic [31:0] bnd_in;
	logic [31:0] b16_in;
	logic [63:0] gen_state;
	logic [31:0] word;
	logic        lcg_busy;
	logic        div_busy;
	logic [31:0] div_rem;
	logic        is_bounded;
	logic        draw_ok;
	logic [5:0]  coins_used;
	logic [4:0]  coin_idx;
	lcg_req_t    lcg_req;
	div_req_t    div_req;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign op_in    = op_t'(s_tdata[2:0]);
	assign bnd_in   = s_tdata[34:3];
	assign b16_in   = {16'd0, s_tdata[18:3]};
	assign word     = pcg_out(gen_state);

	assign is_bounded = (op_q == OP_BND32) || (op_q == OP_BND16);
	assign draw_ok    = (r_q >= thr_q);
	assign coins_used = 6'd32 - coins_left_q;
	assign coin_idx   = coins_used[4:0];

	// Start strobes for the shared units
	always_comb begin
		lcg_req.load      = seed_wr_en;
		lcg_req.seed      = seed_wr_data;
		lcg_req.start     = 1'b0;
		div_req.start     = 1'b0;
		div_req.dividend  = r_q;
		div_req.divisor   = bnd_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op_in)
						OP_RAW32: lcg_req.start = 1'b1;
						OP_RAW16: lcg_req.start = !pending_q;
						OP_COIN:  lcg_req.start = (coins_left_q == 6'd0);
						OP_BND32: begin
							div_req.start    = (bnd_in != 32'd0);
							div_req.dividend = 32'd0 - bnd_in;
							div_req.divisor  = bnd_in;
						end
						OP_BND16: begin
							div_req.start    = (b16_in != 32'd0);
							div_req.dividend = 32'h0001_0000 - b16_in;
							div_req.divisor  = b16_in;
						end
						default: ;
					endcase
				end
			end
			S_DRAW: lcg_req.start = (op_q == OP_BND32) || !pending_q;
			S_ADV:  div_req.start = !lcg_busy && is_bounded && draw_ok;
			default: ;
		endcase
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_RAW32;
			bnd_q        <= '0;
			thr_q        <= '0;
			r_q          <= '0;
			res_q        <= '0;
			bad_q        <= 1'b0;
			pending_q    <= 1'b0;
			upper_q      <= '0;
			coin_word_q  <= '0;
			coins_left_q <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tuser_q    <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != S_DONE))
				m_tvalid_q <= 1'b0;
			if (seed_wr_en) begin
				pending_q    <= 1'b0;
				coins_left_q <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q  <= op_in;
						res_q <= '0;
						bad_q <= 1'b0;
						case (op_in)
							OP_RAW32: begin
								res_q   <= word;
								state_q <= S_ADV;
							end
							OP_BND32: begin
								bnd_q   <= bnd_in;
								bad_q   <= (bnd_in == 32'd0);
								state_q <= (bnd_in == 32'd0) ? S_DONE : S_THR;
							end
							OP_RAW16: begin
								if (pending_q) begin
									res_q     <= {16'd0, upper_q};
									pending_q <= 1'b0;
									state_q   <= S_DONE;
								end else begin
									res_q     <= {16'd0, word[15:0]};
									upper_q   <= word[31:16];
									pending_q <= 1'b1;
									state_q   <= S_ADV;
								end
							end
							OP_BND16: begin
								bnd_q   <= b16_in;
								bad_q   <= (b16_in == 32'd0);
								state_q <= (b16_in == 32'd0) ? S_DONE : S_THR;
							end
							OP_COIN: begin
								if (coins_left_q == 6'd0) begin
									coin_word_q  <= word;
									coins_left_q <= 6'd32;
									state_q      <= S_ADV;
								end else begin
									state_q <= S_COIN;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_THR: begin
					if (!div_busy) begin
						thr_q   <= div_rem;
						state_q <= S_DRAW;
					end
				end
				// One draw for the rejection loop
				S_DRAW: begin
					if (op_q == OP_BND32) begin
						r_q <= word;
					end else if (pending_q) begin
						r_q       <= {16'd0, upper_q};
						pending_q <= 1'b0;
					end else begin
						r_q       <= {16'd0, word[15:0]};
						upper_q   <= word[31:16];
						pending_q <= 1'b1;
					end
					state_q <= S_ADV;
				end
				// Wait for the LCG advance, then route by request
				S_ADV: begin
					if (!lcg_busy) begin
						if (is_bounded)
							state_q <= draw_ok ? S_MODD : S_DRAW;
						else if (op_q == OP_COIN)
							state_q <= S_COIN;
						else
							state_q <= S_DONE;
					end
				end
				S_MODD: begin
					if (!div_busy) begin
						res_q   <= div_rem;
						state_q <= S_DONE;
					end
				end
				S_COIN: begin
					res_q        <= {31'd0, coin_word_q[coin_idx]};
					coins_left_q <= coins_left_q - 6'd1;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= res_q;
						m_tuser_q  <= bad_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	pcg32_lcg u_lcg (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (lcg_req),
		.state  (gen_state),
		.busy   (lcg_busy)
	);

	pcg32_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.busy   (div_busy),
		.rem    (div_rem)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// The remainder unit only runs for the threshold or the final modulo
	assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == S_THR || state_q == S_MODD))
		else $error("remainder unit busy outside threshold/modulo");

	// Never restart the LCG while an advance is in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		lcg_req.start |-> !lcg_busy)
		else $error("LCG started while busy");

	// Coin cache never holds more than one word of bits
	assert property (@(posedge clk) disable iff (!arst_n)
		coins_left_q <= 6'd32)
		else $error("coin count overflow");

	// A zero-bound answer always carries value zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == 32'd0))
		else $error("bad bound with non-zero value");

	// One request at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("request taken while busy");

endmodule

`default_nettype wire
